[rtl/jsu_pkg.sv]
// Shared types, constants and helper functions for the JSON string unescape core.
// Used by jsu_front, jsu_queue, jsu_back and the top level. No dependencies.
`default_nettype none
package jsu_pkg;

   localparam int unsigned JOB_BYTES   = 6;
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_STR,
      PH_ESC,
      PH_HEX
   } phase_type;

   localparam logic [2:0] ERR_NONE        = 3'd0;
   localparam logic [2:0] ERR_NO_OPEN     = 3'd1;
   localparam logic [2:0] ERR_UNTERM_STR  = 3'd2;
   localparam logic [2:0] ERR_UNTERM_ESC  = 3'd3;
   localparam logic [2:0] ERR_TRUNC_UNI   = 3'd4;
   localparam logic [2:0] ERR_BAD_HEX     = 3'd5;
   localparam logic [2:0] ERR_UNKNOWN_ESC = 3'd6;

   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_U      = 8'h75;

   // bytes[0] goes out first
   typedef struct packed {
      logic [JOB_BYTES-1:0][7:0] bytes;
      logic [2:0]                n_bytes;
      logic                      has_status;
      logic                      done;
      logic [2:0]                err;
   } job_type;

   typedef struct packed {
      logic empty;
      logic full;
   } qstat_type;

   typedef struct packed {
      logic [3:0][7:0] bytes;
      logic [2:0]      n;
   } utf8_type;

   function automatic utf8_type utf8_encode(input logic [20:0] cp);
      utf8_type r;
      r = '0;
      if (cp < 21'h80) begin
         r.bytes[0] = cp[7:0];
         r.n        = 3'd1;
      end else if (cp < 21'h800) begin
         r.bytes[0] = {3'b110, cp[10:6]};
         r.bytes[1] = {2'b10, cp[5:0]};
         r.n        = 3'd2;
      end else if (cp < 21'h10000) begin
         r.bytes[0] = {4'b1110, cp[15:12]};
         r.bytes[1] = {2'b10, cp[11:6]};
         r.bytes[2] = {2'b10, cp[5:0]};
         r.n        = 3'd3;
      end else begin
         r.bytes[0] = {5'b11110, cp[20:18]};
         r.bytes[1] = {2'b10, cp[17:12]};
         r.bytes[2] = {2'b10, cp[11:6]};
         r.bytes[3] = {2'b10, cp[5:0]};
         r.n        = 3'd4;
      end
      return r;
   endfunction

   // {valid, value}
   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      logic [7:0] t;
      t = 8'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         t = c - 8'h30;
         return {1'b1, t[3:0]};
      end else if (c >= 8'h61 && c <= 8'h66) begin
         t = c - 8'h57;
         return {1'b1, t[3:0]};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         t = c - 8'h37;
         return {1'b1, t[3:0]};
      end
      return 5'd0;
   endfunction

   // {known, mapped byte}
   function automatic logic [8:0] simple_escape(input logic [7:0] c);
      logic [8:0] r;
      unique case (c)
         8'h22:   r = {1'b1, 8'h22};
         8'h5C:   r = {1'b1, 8'h5C};
         8'h2F:   r = {1'b1, 8'h2F};
         8'h62:   r = {1'b1, 8'h08};
         8'h66:   r = {1'b1, 8'h0C};
         8'h6E:   r = {1'b1, 8'h0A};
         8'h72:   r = {1'b1, 8'h0D};
         8'h74:   r = {1'b1, 8'h09};
         default: r = 9'd0;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

[rtl/jsu_front.sv]
// Front end: accepts document bytes, tracks the string/escape/hex state and
// turns each byte into a job of up to six result bytes plus an optional status.
// Depends on jsu_pkg.
`default_nettype none
module jsu_front
   import jsu_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      req_tvalid,
   output logic           req_tready,
   input  wire logic [7:0] req_tdata,   // text_byte
   input  wire logic      req_tuser,   // end_of_text
   input  wire qstat_type qstat,
   output logic           push,
   output job_type        push_job
);

   phase_type   phase_ff, phase_in;
   logic [15:0] hex_ff, hex_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic [9:0]  held_ff, held_in;
   logic        hold_ff, hold_in;
   logic        in_sec_ff, in_sec_in;

   logic        accept;
   logic        pre;
   utf8_type    main_enc;
   utf8_type    flush_enc;
   logic        has_status;
   logic        done;
   logic [2:0]  err;
   logic [4:0]  hd;
   logic [8:0]  esc;
   logic [15:0] v;
   logic        v_low, v_high;
   logic [20:0] pair_cp;

   assign req_tready = !qstat.full;
   assign accept     = req_tvalid && req_tready;

   assign flush_enc = utf8_encode({5'd0, 6'b110110, held_ff});
   assign hd        = hex_digit(req_tdata);
   assign esc       = simple_escape(req_tdata);
   assign v         = {hex_ff[11:0], hd[3:0]};
   assign v_low     = (v[15:10] == 6'b110111);
   assign v_high    = (v[15:10] == 6'b110110);
   assign pair_cp   = 21'h10000 + {1'b0, held_ff, v[9:0]};

   always_comb begin
      phase_in   = phase_ff;
      hex_in     = hex_ff;
      cnt_in     = cnt_ff;
      held_in    = held_ff;
      hold_in    = hold_ff;
      in_sec_in  = in_sec_ff;
      pre        = 1'b0;
      main_enc   = '0;
      has_status = 1'b0;
      done       = 1'b0;
      err        = ERR_NONE;

      unique case (phase_ff)
         PH_STR: begin
            if (req_tuser) begin
               has_status = 1'b1;
               err        = ERR_UNTERM_STR;
            end else if (req_tdata == CH_BSLASH) begin
               phase_in  = PH_ESC;
               in_sec_in = hold_ff;
            end else if (req_tdata == CH_QUOTE) begin
               pre        = hold_ff;
               has_status = 1'b1;
               done       = 1'b1;
            end else begin
               pre            = hold_ff;
               hold_in        = 1'b0;
               held_in        = '0;
               main_enc.bytes[0] = req_tdata;
               main_enc.n     = 3'd1;
            end
         end
         PH_ESC: begin
            if (req_tuser) begin
               has_status = 1'b1;
               err        = ERR_UNTERM_ESC;
            end else if (req_tdata == CH_U) begin
               phase_in = PH_HEX;
               hex_in   = '0;
               cnt_in   = '0;
            end else if (!esc[8]) begin
               has_status = 1'b1;
               err        = ERR_UNKNOWN_ESC;
            end else begin
               pre            = hold_ff;
               hold_in        = 1'b0;
               held_in        = '0;
               in_sec_in      = 1'b0;
               main_enc.bytes[0] = esc[7:0];
               main_enc.n     = 3'd1;
               phase_in       = PH_STR;
            end
         end
         PH_HEX: begin
            if (req_tuser) begin
               has_status = 1'b1;
               err        = ERR_TRUNC_UNI;
            end else if (!hd[4]) begin
               has_status = 1'b1;
               err        = ERR_BAD_HEX;
            end else if (cnt_ff != 2'd3) begin
               hex_in = v;
               cnt_in = cnt_ff + 2'd1;
            end else begin
               if (in_sec_ff && hold_ff && v_low) begin
                  main_enc = utf8_encode(pair_cp);
                  hold_in  = 1'b0;
                  held_in  = '0;
               end else begin
                  if (in_sec_ff && hold_ff) begin
                     pre     = 1'b1;
                     hold_in = 1'b0;
                     held_in = '0;
                  end
                  // a high surrogate waits for a possible low half
                  if (v_high) begin
                     hold_in = 1'b1;
                     held_in = v[9:0];
                  end else begin
                     main_enc = utf8_encode({5'd0, v});
                  end
               end
               in_sec_in = 1'b0;
               hex_in    = '0;
               cnt_in    = '0;
               phase_in  = PH_STR;
            end
         end
         default: begin
            if (!req_tuser && req_tdata == CH_QUOTE) begin
               phase_in = PH_STR;
            end else begin
               has_status = 1'b1;
               err        = ERR_NO_OPEN;
            end
         end
      endcase

      // errors and the closing quote return everything to reset
      if (has_status) begin
         phase_in  = PH_IDLE;
         hex_in    = '0;
         cnt_in    = '0;
         held_in   = '0;
         hold_in   = 1'b0;
         in_sec_in = 1'b0;
      end
   end

   always_comb begin
      push_job            = '0;
      push_job.has_status = has_status;
      push_job.done       = done;
      push_job.err        = err;
      if (err != ERR_NONE) begin
         push_job.n_bytes = 3'd0;
      end else if (pre) begin
         push_job.bytes[0] = flush_enc.bytes[0];
         push_job.bytes[1] = flush_enc.bytes[1];
         push_job.bytes[2] = flush_enc.bytes[2];
         push_job.bytes[3] = main_enc.bytes[0];
         push_job.bytes[4] = main_enc.bytes[1];
         push_job.bytes[5] = main_enc.bytes[2];
         push_job.n_bytes  = 3'd3 + main_enc.n;
      end else begin
         push_job.bytes[0] = main_enc.bytes[0];
         push_job.bytes[1] = main_enc.bytes[1];
         push_job.bytes[2] = main_enc.bytes[2];
         push_job.bytes[3] = main_enc.bytes[3];
         push_job.n_bytes  = main_enc.n;
      end
   end

   assign push = accept && (has_status || pre || (main_enc.n != 3'd0));

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         hex_ff    <= '0;
         cnt_ff    <= '0;
         held_ff   <= '0;
         hold_ff   <= 1'b0;
         in_sec_ff <= 1'b0;
      end else if (accept) begin
         phase_ff  <= phase_in;
         hex_ff    <= hex_in;
         cnt_ff    <= cnt_in;
         held_ff   <= held_in;
         hold_ff   <= hold_in;
         in_sec_ff <= in_sec_in;
      end
   end

endmodule
`default_nettype wire

[rtl/jsu_queue.sv]
// Short job queue between the front end and the result serialiser.
// Depends on jsu_pkg.
`default_nettype none
module jsu_queue
   import jsu_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire job_type push_job,
   input  wire logic    pop,
   output job_type      head_job,
   output qstat_type    qstat
);

   job_type             slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ff, wr_in;
   logic [QPTR_W-1:0]   rd_ff, rd_in;
   logic [QCNT_W-1:0]   cnt_ff, cnt_in;
   logic                do_push, do_pop;

   assign qstat.empty = (cnt_ff == '0);
   assign qstat.full  = (cnt_ff == QCNT_W'(QUEUE_DEPTH));
   assign do_push     = push && !qstat.full;
   assign do_pop      = pop && !qstat.empty;
   assign head_job    = slot_ff[rd_ff];

   always_comb begin
      wr_in  = do_push ? wr_ff + QPTR_W'(1) : wr_ff;
      rd_in  = do_pop ? rd_ff + QPTR_W'(1) : rd_ff;
      cnt_in = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + QCNT_W'(1);
      end else if (!do_push && do_pop) begin
         cnt_in = cnt_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= push_job;
      end
   end

endmodule
`default_nettype wire

[rtl/jsu_back.sv]
// Back end: walks the head job one result per cycle, while the receiver takes
// results, into a registered result channel. Depends on jsu_pkg.
`default_nettype none
module jsu_back
   import jsu_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire job_type   head_job,
   input  wire qstat_type qstat,
   output logic           pop,
   output logic           rsp_tvalid,
   input  wire logic      rsp_tready,
   output logic [7:0]     rsp_tdata,   // out_byte
   output logic [4:0]     rsp_tuser,   // byte_valid, string_done, error_code[2:0]
   output logic           rsp_tlast
);

   logic [2:0] pos_ff, pos_in;
   logic       vld_ff, vld_in;
   logic [7:0] byte_ff, byte_in;
   logic       bval_ff, bval_in;
   logic       done_ff, done_in;
   logic [2:0] err_ff, err_in;
   logic       last_ff, last_in;
   logic       load;
   logic [2:0] total;

   assign load  = !qstat.empty && (!vld_ff || rsp_tready);
   assign total = head_job.n_bytes + {2'b00, head_job.has_status};

   always_comb begin
      byte_in = 8'd0;
      bval_in = 1'b0;
      done_in = 1'b0;
      err_in  = ERR_NONE;
      if (pos_ff < head_job.n_bytes) begin
         byte_in = head_job.bytes[pos_ff];
         bval_in = 1'b1;
      end else begin
         done_in = head_job.done;
         err_in  = head_job.err;
      end
      last_in = (pos_ff == total - 3'd1);
      pop     = load && last_in;
      pos_in  = pos_ff;
      if (load) begin
         pos_in = last_in ? 3'd0 : pos_ff + 3'd1;
      end
      vld_in = load ? 1'b1 : (rsp_tready ? 1'b0 : vld_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         vld_ff <= 1'b0;
      end else begin
         pos_ff <= pos_in;
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff <= byte_in;
         bval_ff <= bval_in;
         done_ff <= done_in;
         err_ff  <= err_in;
         last_ff <= last_in;
      end
   end

   assign rsp_tvalid = vld_ff;
   assign rsp_tdata  = byte_ff;
   assign rsp_tuser  = {err_ff, done_ff, bval_ff};
   assign rsp_tlast  = last_ff;

endmodule
`default_nettype wire

[rtl/json_string_unescape_utf8_core.sv]
// JSON string unescape core: one document byte in, decoded UTF-8 bytes out.
// Instantiates jsu_front, jsu_queue and jsu_back; depends on jsu_pkg.
//
// Input channel req_*: one document byte per transfer in req_tdata, with
// req_tuser set to mark end of text. Result channel rsp_*: one result per
// transfer; rsp_tdata is the decoded byte, rsp_tuser carries byte_valid,
// string_done and the error code, rsp_tlast marks the final result of the
// input byte that caused it. Bytes such as the opening quote, a backslash,
// hex digits and a held high surrogate produce no result.
// Results of a byte pass through the job queue and then the result register.
// Throughput: one input byte per cycle while the receiver takes results and
// each byte yields at most one result; a byte with n results (up to 6, e.g. a
// flushed surrogate then a three-byte character) holds the serialiser until
// all n are out; the four-entry job queue absorbs such bursts so input flows.
// Reset (synchronous, active high) returns to idle awaiting an opening quote
// and empties the queue. When the receiver stalls, the result register holds;
// the front keeps accepting bytes until the queue is full, then drops
// req_tready.
`default_nettype none
module json_string_unescape_utf8_core
   import jsu_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // text_byte
   input  wire logic       req_tuser,   // end_of_text
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata,   // out_byte
   output logic [4:0]      rsp_tuser,   // byte_valid, string_done, error_code[2:0]
   output logic            rsp_tlast
);

   qstat_type qstat;
   logic      push;
   logic      pop;
   job_type   push_job;
   job_type   head_job;

   jsu_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .qstat      (qstat),
      .push       (push),
      .push_job   (push_job)
   );

   jsu_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .qstat    (qstat)
   );

   jsu_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_job   (head_job),
      .qstat      (qstat),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
`default_nettype wire

[rtl/jsu_checker.sv]
// Port-level checks for json_string_unescape_utf8_core, bound to the top level.
// Depends on jsu_pkg for the error codes.
`default_nettype none
module jsu_checker
   import jsu_pkg::*;
(
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_tvalid,
   input wire logic       req_tready,
   input wire logic [7:0] req_tdata,
   input wire logic       req_tuser,
   input wire logic       rsp_tvalid,
   input wire logic       rsp_tready,
   input wire logic [7:0] rsp_tdata,
   input wire logic [4:0] rsp_tuser,
   input wire logic       rsp_tlast
);

   // stalled result must hold
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   // a data byte never carries done or an error
   a_byte_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> !rsp_tuser[1] && rsp_tuser[4:2] == ERR_NONE)
      else $error("data byte flagged done or error");

   // done and error results close the transfer group of their input byte
   a_status_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser[1] || rsp_tuser[4:2] != ERR_NONE) |-> rsp_tlast)
      else $error("status result not marked last");

   a_err_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser[4:2] != 3'd7)
      else $error("error code out of range");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid straight after reset");

endmodule

bind json_string_unescape_utf8_core jsu_checker u_jsu_checker (.*);
`default_nettype wire
